@@ rtl/core/char_matrix_swap_flip_rotate_unit_assert.svh @@
// Assertion macros shared by the matrix unit RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef CHAR_MATRIX_SWAP_FLIP_ROTATE_UNIT_ASSERT_SVH
`define CHAR_MATRIX_SWAP_FLIP_ROTATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CMSFR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");
`define CMSFR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CMSFR_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define CMSFR_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ rtl/core/cmsfr_pkg.sv @@
// Shared types and constants of the matrix unit.
// No dependencies.
package cmsfr_pkg;

  localparam int IDX_W  = 7;
  localparam int DATA_W = 8;
  localparam int FLD_W  = 6;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] byte_t;

  typedef enum logic [2:0] {
    OP_WRITE, OP_READ, OP_SWAP_CELL, OP_SWAP_ROW,
    OP_SWAP_COL, OP_REV_ROW, OP_REV_COL, OP_ROTATE
  } op_t;

  typedef enum logic {REG_NUM_ROWS, REG_NUM_COLS} reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_READ, S_RWAIT, S_CHK, S_RD, S_WR, S_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    idx_t  ra;
    idx_t  ca;
    idx_t  rb;
    idx_t  cb;
    byte_t value;
    idx_t  nr;
    idx_t  nc;
  } job_t;

  localparam idx_t NUM_ROWS_RST = 7'd8;
  localparam idx_t NUM_COLS_RST = 7'd8;

endpackage

@@ rtl/core/cmsfr_cmd_if.sv @@
// Command channel of the matrix unit: valid/ready plus one operation.
// Depends on cmsfr_pkg.
interface cmsfr_cmd_if;
  import cmsfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       op;
  logic [FLD_W-1:0] row_a;
  logic [FLD_W-1:0] col_a;
  logic [FLD_W-1:0] row_b;
  logic [FLD_W-1:0] col_b;
  byte_t            cell_value;
  modport source(output valid, op, row_a, col_a, row_b, col_b, cell_value, input ready);
  modport sink(input valid, op, row_a, col_a, row_b, col_b, cell_value, output ready);
endinterface

@@ rtl/core/cmsfr_rsp_if.sv @@
// Response channel of the matrix unit: valid/ready plus status and data.
// Depends on cmsfr_pkg.
interface cmsfr_rsp_if;
  import cmsfr_pkg::*;
  logic  valid;
  logic  ready;
  logic  ok;
  byte_t read_value;
  modport source(output valid, ok, read_value, input ready);
  modport sink(input valid, ok, read_value, output ready);
endinterface

@@ rtl/core/cmsfr_ram.sv @@
// Generic simple dual-port RAM: one write, one registered read per cycle.
// No dependencies.
module cmsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ rtl/core/cmsfr_agen.sv @@
// Cell address generator: maps operation, loop indices and group slot
// to a store address. Depends on cmsfr_pkg.
module cmsfr_agen #(
  parameter int MAX_COLS = 64,
  parameter int AW       = 12
) (
  input  cmsfr_pkg::job_t   job,
  input  cmsfr_pkg::idx_t   i,
  input  cmsfr_pkg::idx_t   j,
  input  logic [1:0]        slot,
  output logic [AW-1:0]     addr
);
  import cmsfr_pkg::*;

  idx_t        row, col;
  logic [31:0] lin;

  // rotation group: (i,j) -> (j,n-1-i) -> (n-1-i,n-1-j) -> (n-1-j,i)
  always_comb begin
    row = job.ra;
    col = job.ca;
    case (job.op)
      OP_WRITE, OP_READ: begin
        row = job.ra;
        col = job.ca;
      end
      OP_SWAP_CELL: begin
        row = slot[0] ? job.rb : job.ra;
        col = slot[0] ? job.cb : job.ca;
      end
      OP_SWAP_ROW: begin
        row = slot[0] ? job.rb : job.ra;
        col = j;
      end
      OP_SWAP_COL: begin
        row = j;
        col = slot[0] ? job.cb : job.ca;
      end
      OP_REV_ROW: begin
        row = job.ra;
        col = slot[0] ? (job.nc - 7'd1 - j) : j;
      end
      OP_REV_COL: begin
        row = slot[0] ? (job.nr - 7'd1 - j) : j;
        col = job.ca;
      end
      OP_ROTATE: begin
        case (slot)
          2'd0: begin
            row = i;
            col = j;
          end
          2'd1: begin
            row = j;
            col = job.nr - 7'd1 - i;
          end
          2'd2: begin
            row = job.nr - 7'd1 - i;
            col = job.nr - 7'd1 - j;
          end
          default: begin
            row = job.nr - 7'd1 - j;
            col = i;
          end
        endcase
      end
      default: begin
        row = job.ra;
        col = job.ca;
      end
    endcase
  end

  assign lin  = 32'(row) * 32'(MAX_COLS) + 32'(col);
  assign addr = lin[AW-1:0];
endmodule

@@ rtl/core/char_matrix_swap_flip_rotate_unit.sv @@
// Top level of the byte matrix unit: sequencer, config registers, result reg.
// Depends on cmsfr_pkg, cmsfr_cmd_if, cmsfr_rsp_if, cmsfr_ram, cmsfr_agen.
//
// Usage: num_rows / num_cols are set through the write port (index 0 / 1)
// while the unit is idle. Each command transaction on cmd carries one
// operation and yields exactly one response transaction on rsp (ok plus
// read data, zero unless a successful read).
// Steps per command, from acceptance to the response register:
//   refused command: none; write: one store write; read: one store read
//   and a wait for its registered data; cell/row/column swap and reverse:
//   a check, then two reads and two writes per cell pair; rotation of an
//   n x n matrix: a check, then four reads and four writes per group of four cells.
// These steps are set by the single store RAM: every cell pair is two reads
// and two writes through its one read and one write port.
// A new command is taken only in idle; the response register holds a
// finished result while rsp is stalled, and the unit then takes the next
// command, waiting only if its own result is ready before the previous one
// left. Synchronous reset restores the sizes to 8 x 8 and empties the
// response register; the store content is undefined until written.
`include "char_matrix_swap_flip_rotate_unit_assert.svh"
module char_matrix_swap_flip_rotate_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  cmsfr_pkg::reg_idx_t   cfg_index,
  input  cmsfr_pkg::idx_t       cfg_wdata,
  cmsfr_cmd_if.sink             cmd,
  cmsfr_rsp_if.source           rsp
);
  import cmsfr_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  idx_t   num_rows, num_cols, nr, nc;
  state_t state, state_next;
  job_t   job;
  idx_t   i, j;
  logic [1:0] slot, last_slot;
  byte_t  d [3];
  logic   res_ok;
  byte_t  res_val;
  logic   out_valid, out_ok;
  byte_t  out_val;

  idx_t   c_ra, c_ca, c_rb, c_cb, lim;
  op_t    c_op;
  logic   cmd_ok, cmd_acc, grp_valid, rot_wrap, load_out;
  logic   ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  byte_t  ram_wdata, ram_rdata;
  logic [8:0] ij_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= NUM_ROWS_RST;
      num_cols <= NUM_COLS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows <= cfg_wdata;
        REG_NUM_COLS: num_cols <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nr = ({2'b0, num_rows} > 9'(MAX_ROWS)) ? 7'(MAX_ROWS) : num_rows;
  assign nc = ({2'b0, num_cols} > 9'(MAX_COLS)) ? 7'(MAX_COLS) : num_cols;

  assign c_op = op_t'(cmd.op);
  assign c_ra = {1'b0, cmd.row_a};
  assign c_ca = {1'b0, cmd.col_a};
  assign c_rb = {1'b0, cmd.row_b};
  assign c_cb = {1'b0, cmd.col_b};

  always_comb begin
    case (c_op)
      OP_WRITE, OP_READ: cmd_ok = (c_ra < nr) && (c_ca < nc);
      OP_SWAP_CELL:      cmd_ok = (c_ra < nr) && (c_ca < nc) && (c_rb < nr) && (c_cb < nc);
      OP_SWAP_ROW:       cmd_ok = (c_ra < nr) && (c_rb < nr);
      OP_SWAP_COL:       cmd_ok = (c_ca < nc) && (c_cb < nc);
      OP_REV_ROW:        cmd_ok = c_ra < nr;
      OP_REV_COL:        cmd_ok = c_ca < nc;
      OP_ROTATE:         cmd_ok = nr == nc;
      default:           cmd_ok = 1'b0;
    endcase
  end

  // loop bound of the one-dimensional walks
  always_comb begin
    case (job.op)
      OP_SWAP_CELL: lim = 7'd1;
      OP_SWAP_ROW:  lim = job.nc;
      OP_SWAP_COL:  lim = job.nr;
      OP_REV_ROW:   lim = job.nc >> 1;
      OP_REV_COL:   lim = job.nr >> 1;
      default:      lim = 7'd0;
    endcase
  end

  assign ij_sum    = {2'b0, i} + {2'b0, j};
  assign last_slot = (job.op == OP_ROTATE) ? 2'd3 : 2'd1;
  assign grp_valid = (job.op == OP_ROTATE)
                   ? ((i < (job.nr >> 1)) && (ij_sum + 9'd1 < {2'b0, job.nr}))
                   : (j < lim);
  assign rot_wrap  = !(ij_sum + 9'd2 < {2'b0, job.nr});

  assign cmd_acc  = cmd.valid && cmd.ready;
  assign load_out = (state == S_FIN) && (!out_valid || rsp.ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_acc) begin
          if (!cmd_ok) state_next = S_FIN;
          else if (c_op == OP_WRITE) state_next = S_WRITE;
          else if (c_op == OP_READ) state_next = S_READ;
          else state_next = S_CHK;
        end
      end
      S_WRITE: state_next = S_FIN;
      S_READ:  state_next = S_RWAIT;
      S_RWAIT: state_next = S_FIN;
      S_CHK:   state_next = grp_valid ? S_RD : S_FIN;
      S_RD:    state_next = (slot == last_slot) ? S_WR : S_RD;
      S_WR:    state_next = (slot == last_slot) ? S_CHK : S_WR;
      S_FIN:   state_next = load_out ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs; write slot 0 takes the read still arriving from the RAM
  always_comb begin
    cmd.ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ram_rdata;
    case (state)
      S_IDLE:  cmd.ready = 1'b1;
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = job.value;
      end
      S_READ, S_RD: ram_re = 1'b1;
      S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (slot == 2'd0) ? ram_rdata : d[slot - 2'd1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 2'd0;
    end else if (cmd_acc) begin
      slot <= 2'd0;
    end else if (state == S_RD || state == S_WR) begin
      slot <= (slot == last_slot) ? 2'd0 : slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      job     <= '{op: c_op, ra: c_ra, ca: c_ca, rb: c_rb, cb: c_cb,
                   value: cmd.cell_value, nr: nr, nc: nc};
      res_ok  <= cmd_ok;
      res_val <= '0;
      i       <= '0;
      j       <= '0;
    end else begin
      case (state)
        S_RWAIT: res_val <= ram_rdata;
        S_RD: begin
          if (slot != 2'd0) d[slot - 2'd1] <= ram_rdata;
        end
        S_WR: begin
          if (slot == last_slot) begin
            if (job.op == OP_ROTATE && rot_wrap) begin
              i <= i + 7'd1;
              j <= i + 7'd1;
            end else begin
              j <= j + 7'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ok  <= res_ok;
      out_val <= res_val;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_ok;
  assign rsp.read_value = out_val;

  cmsfr_agen #(.MAX_COLS(MAX_COLS), .AW(AW)) u_agen (
    .job  (job),
    .i    (i),
    .j    (j),
    .slot (slot),
    .addr (ram_addr)
  );

  cmsfr_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  `CMSFR_ASSERT_NXT(a_refused_no_work, clk, rst, cmd_acc && !cmd_ok, state == S_FIN)
  `CMSFR_ASSERT_NXT(a_rsp_held, clk, rst, state == S_FIN && out_valid && !rsp.ready,
                    state == S_FIN && out_valid)
  `CMSFR_ASSERT_IMP(a_slot_in_group, clk, rst, state == S_RD || state == S_WR,
                    slot <= last_slot)
  `CMSFR_ASSERT_IMP(a_no_rw_clash, clk, rst, ram_we, !ram_re)
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for char_matrix_swap_flip_rotate_unit: directed table, then random phases.
// Depends on cmsfr_pkg, cmsfr_cmd_if, cmsfr_rsp_if and the unit itself.
module testbench;
  import cmsfr_pkg::*;

  localparam int DIM       = 64;
  localparam int CYC_LIMIT = 3000000;

  typedef struct {
    op_t        op;
    logic [5:0] ra, ca, rb, cb;
    byte_t      val;
  } matrix_op_t;

  typedef struct {
    logic  ok;
    byte_t rd;
  } matrix_rsp_t;

  typedef struct {
    op_t        op;
    logic [5:0] ra, ca, rb, cb;
    byte_t      val;
    bit         typed;
    logic       ok;
    byte_t      rd;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  reg_idx_t cfg_index = REG_NUM_ROWS;
  idx_t cfg_wdata = '0;

  cmsfr_cmd_if cmd_ch();
  cmsfr_rsp_if rsp_ch();

  char_matrix_swap_flip_rotate_unit DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cmd(cmd_ch), .rsp(rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: bytes plus a written flag that travels with each byte
  byte_t cells [DIM*DIM];
  bit    known [DIM*DIM];
  int    used_rows = 8, used_cols = 8;
  matrix_rsp_t pending_rsp[$];
  int    fail_cnt = 0;
  int    cycle_cnt = 0;
  int    burst_left = 0;
  bit    long_hold_req = 0;

  function automatic void swap_cells(int p, int q);
    byte_t tb;
    bit    tk;
    tb = cells[p]; cells[p] = cells[q]; cells[q] = tb;
    tk = known[p]; known[p] = known[q]; known[q] = tk;
  endfunction

  function automatic matrix_rsp_t apply_matrix_op(matrix_op_t it);
    matrix_rsp_t r;
    int nr, nc;
    byte_t cb [DIM*DIM];
    bit    kb [DIM*DIM];
    nr = used_rows; nc = used_cols;
    r.ok = 1'b0; r.rd = '0;
    case (it.op)
      OP_WRITE: if (it.ra < nr && it.ca < nc) begin
        cells[it.ra*DIM+it.ca] = it.val; known[it.ra*DIM+it.ca] = 1; r.ok = 1'b1;
      end
      OP_READ: if (it.ra < nr && it.ca < nc) begin
        r.rd = cells[it.ra*DIM+it.ca]; r.ok = 1'b1;
      end
      OP_SWAP_CELL: if (it.ra < nr && it.ca < nc && it.rb < nr && it.cb < nc) begin
        swap_cells(it.ra*DIM+it.ca, it.rb*DIM+it.cb); r.ok = 1'b1;
      end
      OP_SWAP_ROW: if (it.ra < nr && it.rb < nr) begin
        for (int j = 0; j < nc; j++) swap_cells(it.ra*DIM+j, it.rb*DIM+j);
        r.ok = 1'b1;
      end
      OP_SWAP_COL: if (it.ca < nc && it.cb < nc) begin
        for (int i = 0; i < nr; i++) swap_cells(i*DIM+it.ca, i*DIM+it.cb);
        r.ok = 1'b1;
      end
      OP_REV_ROW: if (it.ra < nr) begin
        for (int j = 0; j < nc/2; j++) swap_cells(it.ra*DIM+j, it.ra*DIM+nc-1-j);
        r.ok = 1'b1;
      end
      OP_REV_COL: if (it.ca < nc) begin
        for (int i = 0; i < nr/2; i++) swap_cells(i*DIM+it.ca, (nr-1-i)*DIM+it.ca);
        r.ok = 1'b1;
      end
      default: if (nr == nc) begin
        cb = cells; kb = known;
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++) begin
            cells[i*DIM+j] = cb[(nr-1-j)*DIM+i];
            known[i*DIM+j] = kb[(nr-1-j)*DIM+i];
          end
        r.ok = 1'b1;
      end
    endcase
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_op(matrix_op_t it, bit typed, logic eok, byte_t erd);
    matrix_rsp_t r;
    if (burst_left == 0) begin
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    cmd_ch.valid = 1'b1;
    cmd_ch.op = it.op;
    cmd_ch.row_a = it.ra; cmd_ch.col_a = it.ca;
    cmd_ch.row_b = it.rb; cmd_ch.col_b = it.cb;
    cmd_ch.cell_value = it.val;
    do @(posedge clk); while (!cmd_ch.ready);
    r = apply_matrix_op(it);
    if (typed) begin
      r.ok = eok; r.rd = erd;
    end
    pending_rsp.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_ch.valid = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_size(int rows, int cols);
    cfg_wr_en = 1'b1; cfg_index = REG_NUM_ROWS; cfg_wdata = idx_t'(rows);
    @(negedge clk);
    cfg_index = REG_NUM_COLS; cfg_wdata = idx_t'(cols);
    @(negedge clk);
    cfg_wr_en = 1'b0;
    used_rows = rows > DIM ? DIM : rows;
    used_cols = cols > DIM ? DIM : cols;
  endtask

  function automatic logic [5:0] pick_idx(int n);
    if (n > 0 && $urandom_range(0, 9) != 0) return 6'($urandom_range(0, n-1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic matrix_op_t random_op();
    matrix_op_t it;
    int w;
    w = $urandom_range(0, 99);
    if (w < 30) it.op = OP_WRITE;
    else if (w < 52) it.op = OP_READ;
    else if (w < 96) it.op = op_t'($urandom_range(2, 6));
    else it.op = OP_ROTATE;
    it.ra = pick_idx(used_rows); it.ca = pick_idx(used_cols);
    it.rb = pick_idx(used_rows); it.cb = pick_idx(used_cols);
    it.val = byte_t'($urandom_range(0, 255));
    // a read of a never-written cell is not allowed; write it instead
    if (it.op == OP_READ && it.ra < used_rows && it.ca < used_cols &&
        !known[it.ra*DIM+it.ca])
      it.op = OP_WRITE;
    return it;
  endfunction

  // response checker
  always @(posedge clk) begin
    matrix_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response transaction with nothing expected");
        fail_cnt++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_ch.ok !== e.ok) begin
          $error("ok: expected %0d actual %0d", e.ok, rsp_ch.ok);
          fail_cnt++;
        end
        if (rsp_ch.read_value !== e.rd) begin
          $error("read_value: expected %0h actual %0h", e.rd, rsp_ch.read_value);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: rotating stall modes plus one long hold on request
  int hold_left = 0;
  int rx_cnt = 0;
  always @(negedge clk) begin
    rx_cnt++;
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      case ((rx_cnt / 64) % 4)
        0: rsp_ch.ready = 1'b1;
        1: rsp_ch.ready = 1'($urandom_range(0, 1));
        2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
        default: rsp_ch.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("char_matrix_swap_flip_rotate_unit regression: fail");
      $finish;
    end
  end

  table_row_t dir_tbl [] = '{
    '{OP_WRITE,     0, 0, 0, 0, 8'h00, 1, 1'b1, 8'h00},
    '{OP_WRITE,     7, 7, 0, 0, 8'hFF, 1, 1'b1, 8'h00},
    '{OP_READ,      7, 7, 0, 0, 8'h00, 1, 1'b1, 8'hFF},
    '{OP_READ,      0, 0, 0, 0, 8'h00, 1, 1'b1, 8'h00},
    '{OP_WRITE,     8, 0, 0, 0, 8'h5A, 1, 1'b0, 8'h00},
    '{OP_WRITE,     0, 63, 0, 0, 8'hA5, 1, 1'b0, 8'h00},
    '{OP_READ,      63, 0, 0, 0, 8'h00, 1, 1'b0, 8'h00},
    '{OP_SWAP_CELL, 0, 0, 7, 7, 8'h00, 1, 1'b1, 8'h00},
    '{OP_READ,      0, 0, 0, 0, 8'h00, 1, 1'b1, 8'hFF},
    '{OP_SWAP_CELL, 0, 0, 8, 7, 8'h00, 1, 1'b0, 8'h00},
    '{OP_WRITE,     0, 7, 0, 0, 8'h3C, 0, 1'b0, 8'h00},
    '{OP_WRITE,     7, 0, 0, 0, 8'hC3, 0, 1'b0, 8'h00},
    '{OP_SWAP_ROW,  0, 0, 7, 0, 8'h00, 1, 1'b1, 8'h00},
    '{OP_SWAP_ROW,  0, 0, 42, 0, 8'h00, 1, 1'b0, 8'h00},
    '{OP_SWAP_COL,  0, 0, 0, 7, 8'h00, 1, 1'b1, 8'h00},
    '{OP_SWAP_COL,  0, 21, 0, 7, 8'h00, 1, 1'b0, 8'h00},
    '{OP_REV_ROW,   0, 0, 0, 0, 8'h00, 1, 1'b1, 8'h00},
    '{OP_REV_ROW,   8, 0, 0, 0, 8'h00, 1, 1'b0, 8'h00},
    '{OP_REV_COL,   0, 7, 0, 0, 8'h00, 1, 1'b1, 8'h00},
    '{OP_REV_COL,   0, 8, 0, 0, 8'h00, 1, 1'b0, 8'h00},
    '{OP_ROTATE,    0, 0, 0, 0, 8'h00, 1, 1'b1, 8'h00},
    '{OP_READ,      0, 0, 0, 0, 8'h00, 0, 1'b0, 8'h00},
    '{OP_READ,      7, 0, 0, 0, 8'h00, 0, 1'b0, 8'h00},
    '{OP_READ,      0, 7, 0, 0, 8'h00, 0, 1'b0, 8'h00},
    '{OP_READ,      7, 7, 0, 0, 8'h00, 0, 1'b0, 8'h00}
  };

  int ph_rows [] = '{1, 4, 3, 64, 0, 0, 127, 5, 1, 64, 8, 7, 2};
  int ph_cols [] = '{1, 4, 5, 64, 5, 0, 127, 3, 64, 1, 8, 7, 2};
  int ph_cnt  [] = '{120, 250, 250, 60, 30, 20, 40, 250, 120, 120, 300, 250, 140};

  initial begin
    matrix_op_t it;
    cmd_ch.valid = 1'b0; cmd_ch.op = '0;
    cmd_ch.row_a = '0; cmd_ch.col_a = '0; cmd_ch.row_b = '0; cmd_ch.col_b = '0;
    cmd_ch.cell_value = '0;
    rsp_ch.ready = 1'b0;
    foreach (known[k]) begin
      known[k] = 0; cells[k] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows run on the reset size of 8 x 8
    foreach (dir_tbl[k]) begin
      it.op = dir_tbl[k].op; it.ra = dir_tbl[k].ra; it.ca = dir_tbl[k].ca;
      it.rb = dir_tbl[k].rb; it.cb = dir_tbl[k].cb; it.val = dir_tbl[k].val;
      send_op(it, dir_tbl[k].typed, dir_tbl[k].ok, dir_tbl[k].rd);
    end

    foreach (ph_cnt[p]) begin
      drain();
      set_size(ph_rows[p], ph_cols[p]);
      if (ph_rows[p] == 4) long_hold_req = 1;
      for (int n = 0; n < ph_cnt[p]; n++) begin
        if (ph_rows[p] == 8 && n == ph_cnt[p] / 2) begin
          cmd_ch.valid = 1'b0;
          wait (pending_rsp.size() == 0);
          @(negedge clk);
        end
        send_op(random_op(), 0, 1'b0, 8'h00);
      end
    end

    cmd_ch.valid = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && pending_rsp.size() == 0)
      $display("char_matrix_swap_flip_rotate_unit regression: pass");
    else
      $display("char_matrix_swap_flip_rotate_unit regression: fail");
    $finish;
  end

endmodule
